// ===== design/lphs_pkg.sv =====
// Shared types and constants for the linear-probe hash set core.
// Holds op, status and outcome codes, controller states and the command/status structs.
// Used by every module of the block; depends on nothing else.
package lphs_pkg;

	localparam int KEY_W = 64;
	localparam int CAP_W = 13;
	localparam int CNT_W = 13;
	localparam int OUT_W = 16;
	localparam int CAP_LIMIT = 8191;
	localparam int CAP_RESET = 4096;
	localparam int DIV_BITS = 4;
	localparam int DIV_STEPS = KEY_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [KEY_W-1:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

	localparam logic [1:0] HS_LOW = 2'd0;
	localparam logic [1:0] HS_KEY_HI = 2'd1;
	localparam logic [1:0] HS_MUL_HI = 2'd2;
	localparam logic [1:0] HS_LAST = 2'd3;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		INS_OK = 2'd0,
		INS_DUP = 2'd1,
		INS_FULL = 2'd2,
		INS_LIMIT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OUT_FOUND = 2'd0,
		OUT_EMPTY = 2'd1,
		OUT_LIMIT = 2'd2,
		OUT_FULL = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		S_BOOT,
		S_IDLE,
		S_HASH,
		S_DIV,
		S_PINIT,
		S_PROBE,
		S_CLEAR,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic load;
		logic count_clr;
		logic sweep;
		logic hash;
		logic div;
		logic pinit;
		logic probe;
		logic set_full;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic load_full;
		logic sweep_last;
		logic hash_done;
		logic div_done;
		logic probe_done;
		logic out_free;
	} sts_t;

endpackage

// ===== design/lphs_ctrl.sv =====
// Controller state machine of the linear-probe hash set core.
// Sequences sweep, hash, divide, probe and result steps through cmd_t and sts_t.
// Depends on lphs_pkg.
module lphs_ctrl import lphs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic [1:0] s_tuser,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	op_t op_in;

	assign op_in = op_t'(s_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			S_BOOT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					case (op_in)
						OP_LOOKUP: state_nxt = S_HASH;
						OP_INSERT: begin
							if (sts.load_full) begin
								cmd.set_full = 1'b1;
								state_nxt = S_RESULT;
							end else begin
								state_nxt = S_HASH;
							end
						end
						OP_CLEAR: begin
							cmd.count_clr = 1'b1;
							state_nxt = S_CLEAR;
						end
						default: state_nxt = S_RESULT;
					endcase
				end
			end
			S_HASH: begin
				cmd.hash = 1'b1;
				if (sts.hash_done) begin
					state_nxt = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_done) begin
					state_nxt = S_PINIT;
				end
			end
			S_PINIT: begin
				cmd.pinit = 1'b1;
				state_nxt = S_PROBE;
			end
			S_PROBE: begin
				cmd.probe = 1'b1;
				if (sts.probe_done) begin
					state_nxt = S_RESULT;
				end
			end
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = S_RESULT;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_BOOT;
		endcase
	end

endmodule

// ===== design/lphs_dp.sv =====
// Datapath of the linear-probe hash set core: key hash, home-slot divider, slot memory,
// probe pipeline, entry counter, capacity register and output register.
// Depends on lphs_pkg; driven by lphs_ctrl through cmd_t.
module lphs_dp import lphs_pkg::*; #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_PROBES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  logic [KEY_W-1:0] s_tdata,
	input  logic [1:0] s_tuser,
	input  logic cfg_valid,
	input  logic [CAP_W-1:0] cfg_data,
	input  logic m_tready,
	output logic m_tvalid,
	output logic [OUT_W-1:0] m_tdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int PW = $clog2(MAX_PROBES + 1);
	localparam int XW = (AW > CAP_W) ? AW : CAP_W;
	localparam int CAP_TOP = (TABLE_DEPTH < CAP_LIMIT) ? TABLE_DEPTH : CAP_LIMIT;
	localparam int CAP_INIT = (TABLE_DEPTH < CAP_RESET) ? TABLE_DEPTH : CAP_RESET;
	localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(CAP_TOP);
	localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(CAP_INIT);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
	localparam logic [PW-1:0] PROBE_LAST = PW'(MAX_PROBES - 1);
	localparam logic [PW-1:0] PROBE_NUM = PW'(MAX_PROBES);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	logic [KEY_W-1:0] slot_mem_q [TABLE_DEPTH];

	logic [CAP_W-1:0] cap_q;
	logic [KEY_W-1:0] key_q;
	op_t op_q;
	logic [1:0] hstep_q;
	logic [KEY_W-1:0] mul_q;
	logic [KEY_W-1:0] acc_q;
	logic [DIV_CNT_W-1:0] dcnt_q;
	logic [CAP_W-1:0] rem_q;
	logic [AW-1:0] issue_idx_q;
	logic [PW-1:0] issued_q;
	logic [KEY_W-1:0] rd_data_s1;
	logic [AW-1:0] rd_idx_s1;
	logic rd_vld_s1;
	logic rd_last_s1;
	outcome_t outcome_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0] sw_addr_q;
	logic out_vld_q;
	logic [OUT_W-1:0] out_data_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [KEY_W-1:0] prod;
	logic [CAP_W-1:0] rem_nxt;
	logic [XW:0] idx_inc;
	logic [AW-1:0] idx_next;
	logic hit;
	logic empty;
	logic probe_done;
	logic commit_we;
	logic issue_ok;
	logic present_w;
	status_t status_w;
	logic [CAP_W+1:0] cnt_x4;
	logic [CAP_W+1:0] cap_x3;

	assign mul_a = (hstep_q == HS_KEY_HI) ? key_q[63:32] : key_q[31:0];
	assign mul_b = (hstep_q == HS_MUL_HI) ? GOLDEN[63:32] : GOLDEN[31:0];
	assign prod = mul_a * mul_b;

	always_comb begin
		logic [CAP_W-1:0] r;
		logic [CAP_W:0] t;
		r = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r, acc_q[KEY_W-1-i]};
			if (t >= {1'b0, cap_q}) begin
				t = t - {1'b0, cap_q};
			end
			r = t[CAP_W-1:0];
		end
		rem_nxt = r;
	end

	assign idx_inc = (XW + 1)'(issue_idx_q) + 1'b1;
	assign idx_next = (idx_inc >= (XW + 1)'(cap_q)) ? '0 : AW'(idx_inc);
	assign issue_ok = (issued_q != PROBE_NUM);

	assign hit = (rd_data_s1 == key_q);
	assign empty = (rd_data_s1 == EMPTY_KEY);
	assign probe_done = rd_vld_s1 & (hit | empty | rd_last_s1);
	assign commit_we = cmd.probe & rd_vld_s1 & ~hit & empty & (op_q == OP_INSERT);

	assign cnt_x4 = {cnt_q, 2'b00};
	assign cap_x3 = {2'b00, cap_q} + {1'b0, cap_q, 1'b0};

	assign sts.load_full = (cnt_x4 >= cap_x3);
	assign sts.sweep_last = (sw_addr_q == LAST_ADDR);
	assign sts.hash_done = (hstep_q == HS_LAST);
	assign sts.div_done = (dcnt_q == DIV_LAST);
	assign sts.probe_done = probe_done;
	assign sts.out_free = ~out_vld_q | m_tready;

	always_comb begin
		present_w = (op_q == OP_LOOKUP) && (outcome_q == OUT_FOUND);
		status_w = INS_OK;
		if (op_q == OP_INSERT) begin
			case (outcome_q)
				OUT_FOUND: status_w = INS_DUP;
				OUT_EMPTY: status_w = INS_OK;
				OUT_FULL: status_w = INS_FULL;
				default: status_w = INS_LIMIT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			slot_mem_q[sw_addr_q] <= EMPTY_KEY;
		end else if (commit_we) begin
			slot_mem_q[rd_idx_s1] <= key_q;
		end
		if (cmd.probe) begin
			rd_data_s1 <= slot_mem_q[issue_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= s_tdata;
			op_q <= op_t'(s_tuser);
			rem_q <= '0;
		end
		if (cmd.hash) begin
			mul_q <= prod;
			case (hstep_q)
				HS_LOW: acc_q <= acc_q;
				HS_KEY_HI: acc_q <= mul_q;
				default: acc_q[63:32] <= acc_q[63:32] + mul_q[31:0];
			endcase
		end
		if (cmd.div) begin
			rem_q <= rem_nxt;
			acc_q <= acc_q << DIV_BITS;
		end
		if (cmd.pinit) begin
			issue_idx_q <= AW'(rem_q);
		end
		if (cmd.probe && issue_ok) begin
			rd_idx_s1 <= issue_idx_q;
			rd_last_s1 <= (issued_q == PROBE_LAST);
			issue_idx_q <= idx_next;
		end
		if (cmd.set_full) begin
			outcome_q <= OUT_FULL;
		end else if (cmd.probe && probe_done) begin
			if (hit) begin
				outcome_q <= OUT_FOUND;
			end else if (empty) begin
				outcome_q <= OUT_EMPTY;
			end else begin
				outcome_q <= OUT_LIMIT;
			end
		end
		if (cmd.emit) begin
			out_data_q <= {cnt_q, status_w, present_w};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RST;
			hstep_q <= '0;
			dcnt_q <= '0;
			issued_q <= '0;
			rd_vld_s1 <= 1'b0;
			cnt_q <= '0;
			sw_addr_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_data == '0) begin
					cap_q <= CAP_W'(1);
				end else if (cfg_data > CAP_MAX) begin
					cap_q <= CAP_MAX;
				end else begin
					cap_q <= cfg_data;
				end
			end
			if (cmd.load) begin
				hstep_q <= '0;
				dcnt_q <= '0;
			end
			if (cmd.hash) begin
				hstep_q <= hstep_q + 1'b1;
			end
			if (cmd.div) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.pinit) begin
				issued_q <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.probe) begin
				rd_vld_s1 <= issue_ok;
				if (issue_ok) begin
					issued_q <= issued_q + 1'b1;
				end
			end
			if (cmd.count_clr) begin
				cnt_q <= '0;
			end else if (commit_we) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.sweep) begin
				sw_addr_q <= sts.sweep_last ? '0 : sw_addr_q + 1'b1;
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;

endmodule

// ===== design/linear_probe_hash_set_core.sv =====
// Linear-probe hash set of 64-bit keys in an on-chip table of TABLE_DEPTH slots. After reset the
// block empties the table and accepts no beat meanwhile; the capacity port is open at all times.
// It works on one operation at a time. A lookup or insert probes 1 to MAX_PROBES slots: it
// hashes the key on a shared 32x32 multiplier, finds the home slot by division by capacity at
// four bits per cycle, then makes one slot-memory read per cycle.
// An insert refused for load goes straight to the result; a clear empties one slot per cycle.
// A finished result sits in the output register, so the next beat is accepted while it waits.
// Depends on lphs_pkg, lphs_ctrl and lphs_dp.
module linear_probe_hash_set_core import lphs_pkg::*; #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_PROBES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata,   // [63:0] key
	input  logic [1:0] s_tuser,    // [1:0] op
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata,   // [0] present, [2:1] status, [15:3] entries
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [12:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lphs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tuser(s_tuser),
		.s_tready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	lphs_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.MAX_PROBES(MAX_PROBES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata(m_tdata)
	);

endmodule

// ===== design/lphs_chk.sv =====
// Port-level checker for the linear-probe hash set core, bound to the top level.
// Watches the input and output stream ports only; depends on lphs_pkg for the status codes.
module lphs_chk import lphs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result beat keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// The block works on one operation at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted during an operation");

	// Present and a nonzero insert status never come together.
	a_fields_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && (m_tdata[2:1] != INS_OK)))
		else $error("present and status both set");

	// The load limit keeps the stored count within three quarters of the largest capacity, rounded up.
	a_entries_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:3] <= 13'd6144))
		else $error("entries above the load limit");

endmodule

bind linear_probe_hash_set_core lphs_chk u_lphs_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
